[design/ytr_pkg.sv]
// Shared types and constants of the YUV to RGBA rotating writer.
package ytr_pkg;

  localparam int MAX_DIM = 4096;
  localparam int DIM_W   = $clog2(MAX_DIM + 1);
  localparam int CNT_W   = $clog2(MAX_DIM);
  localparam int IDX_W   = 24;
  localparam int CFG_W   = 13;
  localparam int REG_IDX_W = 2;
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W  = $clog2(QDEPTH + 1);
  localparam int ACC_W   = 21;

  localparam logic [REG_IDX_W-1:0] REG_WIDTH    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_HEIGHT   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_ROTATION = 2'd2;

  localparam logic [CFG_W-1:0] RESET_WIDTH  = 13'd640;
  localparam logic [CFG_W-1:0] RESET_HEIGHT = 13'd480;

  localparam logic signed [ACC_W-1:0] K_Y    = 21'sd1192;
  localparam logic signed [ACC_W-1:0] K_RV   = 21'sd1634;
  localparam logic signed [ACC_W-1:0] K_GV   = 21'sd833;
  localparam logic signed [ACC_W-1:0] K_GU   = 21'sd400;
  localparam logic signed [ACC_W-1:0] K_BU   = 21'sd2066;
  localparam logic signed [ACC_W-1:0] CH_MAX = 21'sd262143;
  localparam logic signed [ACC_W-1:0] C_OFS  = 21'sd128;
  localparam logic [7:0] Y_OFS = 8'd16;
  localparam logic [7:0] ALPHA = 8'hff;

  typedef enum logic [1:0] {
    ROT_0   = 2'd0,
    ROT_90  = 2'd1,
    ROT_180 = 2'd2,
    ROT_270 = 2'd3
  } rot_e;

  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    rot_e             rot;
  } cfg_t;

  // One classified pixel: samples plus index terms, index = major * pitch + minor.
  typedef struct packed {
    logic [7:0]       luma;
    logic [7:0]       cb;
    logic [7:0]       cr;
    logic [CNT_W-1:0] major;
    logic [CNT_W-1:0] minor;
    logic             last;
  } entry_t;

endpackage

[design/ytr_front.sv]
// Front end: configuration registers, raster counters and index classification.
module ytr_front
  import ytr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [REG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 take_i,
  input  logic [7:0]           luma_i,
  input  logic [7:0]           chroma_blue_i,
  input  logic [7:0]           chroma_red_i,
  output entry_t               entry_o,
  output cfg_t                 cfg_o
);

  logic [CFG_W-1:0] width_q, width_d, height_q, height_d;
  rot_e             rot_q, rot_d;
  logic [CNT_W-1:0] x_q, x_d, y_q, y_d;
  logic [DIM_W-1:0] w_eff, h_eff;
  logic [CNT_W-1:0] x_rev, y_rev;
  logic             x_wrap, y_wrap;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) r = DIM_W'(1);
    else if (32'(v) > MAX_DIM) r = DIM_W'(MAX_DIM);
    else r = DIM_W'(v);
    return r;
  endfunction

  assign w_eff = eff_dim(width_q);
  assign h_eff = eff_dim(height_q);

  assign x_wrap = (DIM_W'(x_q) + DIM_W'(1)) >= w_eff;
  assign y_wrap = (DIM_W'(y_q) + DIM_W'(1)) >= h_eff;
  assign x_rev  = CNT_W'(w_eff - DIM_W'(1) - DIM_W'(x_q));
  assign y_rev  = CNT_W'(h_eff - DIM_W'(1) - DIM_W'(y_q));

  always_comb begin
    entry_o.luma = luma_i;
    entry_o.cb   = chroma_blue_i;
    entry_o.cr   = chroma_red_i;
    entry_o.last = x_wrap && y_wrap;
    case (rot_q)
      ROT_0: begin
        entry_o.major = y_q;
        entry_o.minor = x_q;
      end
      ROT_90: begin
        entry_o.major = x_q;
        entry_o.minor = y_rev;
      end
      ROT_180: begin
        entry_o.major = y_rev;
        entry_o.minor = x_rev;
      end
      default: begin
        entry_o.major = x_rev;
        entry_o.minor = y_q;
      end
    endcase
  end

  assign cfg_o.width  = w_eff;
  assign cfg_o.height = h_eff;
  assign cfg_o.rot    = rot_q;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    rot_d    = rot_q;
    x_d      = x_q;
    y_d      = y_q;
    if (take_i) begin
      if (x_wrap) begin
        x_d = '0;
        y_d = y_wrap ? '0 : y_q + CNT_W'(1);
      end else begin
        x_d = x_q + CNT_W'(1);
      end
    end
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_WIDTH: begin
          width_d = cfg_data_i;
          x_d     = '0;
          y_d     = '0;
        end
        REG_HEIGHT: begin
          height_d = cfg_data_i;
          x_d      = '0;
          y_d      = '0;
        end
        REG_ROTATION: rot_d = rot_e'(cfg_data_i[1:0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RESET_WIDTH;
      height_q <= RESET_HEIGHT;
      rot_q    <= ROT_0;
      x_q      <= '0;
      y_q      <= '0;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      rot_q    <= rot_d;
      x_q      <= x_d;
      y_q      <= y_d;
    end
  end

  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    DIM_W'(x_q) < w_eff) else $error("column counter beyond width");
  a_row_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    DIM_W'(y_q) < h_eff) else $error("row counter beyond height");
  a_dim_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_we_i && (cfg_idx_i == REG_WIDTH || cfg_idx_i == REG_HEIGHT))
    |=> (x_q == '0 && y_q == '0)) else $error("dimension write did not restart frame");

endmodule

[design/ytr_queue.sv]
// Short flop queue between front end and back end.
module ytr_queue
  import ytr_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   wr_i,
  input  entry_t wr_data_i,
  output logic   full_o,
  input  logic   rd_i,
  output logic   valid_o,
  output entry_t rd_data_o
);

  entry_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0]   wp_q, wp_d, rp_q, rp_d;
  logic [QCNT_W-1:0]   cnt_q, cnt_d;
  logic                do_wr, do_rd;

  assign full_o    = cnt_q == QCNT_W'(QDEPTH);
  assign valid_o   = cnt_q != '0;
  assign rd_data_o = mem_q[rp_q];
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && valid_o;

  function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  always_comb begin
    wp_d  = do_wr ? bump(wp_q) : wp_q;
    rp_d  = do_rd ? bump(rp_q) : rp_q;
    cnt_d = cnt_q;
    if (do_wr && !do_rd) cnt_d = cnt_q + QCNT_W'(1);
    else if (!do_wr && do_rd) cnt_d = cnt_q - QCNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wp_q] <= wr_data_i;
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QDEPTH)) else $error("queue overfilled");
  a_cnt_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_wr && !do_rd) |=> cnt_q == $past(cnt_q) + QCNT_W'(1))
    else $error("queue count missed a write");
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 || full_o) |-> wp_q == rp_q) else $error("queue pointers out of step");

endmodule

[design/ytr_back.sv]
// Back end: two-stage color matrix and destination index pipeline.
module ytr_back
  import ytr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             q_valid_i,
  input  entry_t           q_data_i,
  output logic             q_pop_o,
  output logic             empty,
  input  logic             pop,
  output logic [31:0]      pixel_rgba_o,
  output logic [IDX_W-1:0] dest_index_o,
  output logic             frame_last_o
);

  logic v1_q, v1_d, v2_q, v2_d, adv1, adv2;

  logic signed [ACC_W-1:0] ys, us, vs;
  logic signed [ACC_W-1:0] py_q, prv_q, pgv_q, pgu_q, pbu_q;
  logic [IDX_W-1:0]        pidx_q, minor_q;
  logic [DIM_W-1:0]        pitch;
  logic                    last1_q;

  logic signed [ACC_W-1:0] r_s, g_s, b_s;
  logic [31:0]             rgba_q;
  logic [IDX_W-1:0]        idx_q;
  logic                    last2_q;

  function automatic logic [7:0] clamp8(input logic signed [ACC_W-1:0] c);
    logic [7:0] r;
    if (c < 0) r = 8'd0;
    else if (c > CH_MAX) r = 8'hff;
    else r = c[17:10];
    return r;
  endfunction

  assign adv2    = !v2_q || pop;
  assign adv1    = !v1_q || adv2;
  assign q_pop_o = adv1 && q_valid_i;
  assign v1_d    = adv1 ? q_valid_i : v1_q;
  assign v2_d    = adv2 ? v1_q : v2_q;

  assign ys    = (q_data_i.luma < Y_OFS) ? '0 : $signed(ACC_W'(q_data_i.luma - Y_OFS));
  assign us    = $signed(ACC_W'(q_data_i.cb)) - C_OFS;
  assign vs    = $signed(ACC_W'(q_data_i.cr)) - C_OFS;
  assign pitch = cfg_i.rot[0] ? cfg_i.height : cfg_i.width;

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      py_q    <= ys * K_Y;
      prv_q   <= vs * K_RV;
      pgv_q   <= vs * K_GV;
      pgu_q   <= us * K_GU;
      pbu_q   <= us * K_BU;
      pidx_q  <= IDX_W'(q_data_i.major) * IDX_W'(pitch);
      minor_q <= IDX_W'(q_data_i.minor);
      last1_q <= q_data_i.last;
    end
  end

  assign r_s = py_q + prv_q;
  assign g_s = py_q - pgv_q - pgu_q;
  assign b_s = py_q + pbu_q;

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      rgba_q  <= {ALPHA, clamp8(r_s), clamp8(g_s), clamp8(b_s)};
      idx_q   <= pidx_q + minor_q;
      last2_q <= last1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
    end
  end

  assign empty        = !v2_q;
  assign pixel_rgba_o = rgba_q;
  assign dest_index_o = idx_q;
  assign frame_last_o = last2_q;

  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && !adv1) |=> v1_q) else $error("stage one dropped a beat");
  a_no_pop_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> v1_q) else $error("popped beat not loaded");
  a_stage_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && adv2) |=> v2_q) else $error("beat lost between stages");

endmodule

[design/yuv_to_rgba_rotating_writer.sv]
// Top level of the YUV to RGBA converter with rotated destination index.
//
// Input side is a queue: drive luma/chroma with push; a beat is taken when
// push is high and full is low. Result side is a queue too: while empty is
// low the oldest result sits on pixel_rgba_o, dest_index_o and frame_last_o;
// pop takes it. One result per pixel, in order.
// Configuration: cfg_we_i, cfg_idx_i (0 width, 1 height, 2 rotation),
// cfg_data_i. Write only while idle. Width or height writes restart the frame.
// Throughput: one pixel per cycle while the receiver pops each result. The
// front end classifies a pixel in the cycle it is taken and places it in a
// two-entry queue; the back end runs a two-stage pipeline (registered
// multiplies, then sums, clamps and the index add) into the output register.
// When the receiver stalls, the pipeline holds and the queue fills; full
// rises after the queue and pipeline hold four pixels.
// Reset: 640x480, no rotation, counters at zero, all queues empty.
module yuv_to_rgba_rotating_writer
  import ytr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [REG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 push,
  output logic                 full,
  input  logic [7:0]           luma_i,
  input  logic [7:0]           chroma_blue_i,
  input  logic [7:0]           chroma_red_i,
  output logic                 empty,
  input  logic                 pop,
  output logic [31:0]          pixel_rgba_o,
  output logic [IDX_W-1:0]     dest_index_o,
  output logic                 frame_last_o
);

  entry_t fe_entry, q_entry;
  cfg_t   cfg;
  logic   take, q_valid, q_pop;

  assign take = push && !full;

  ytr_front u_front (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .take_i        (take),
    .luma_i,
    .chroma_blue_i,
    .chroma_red_i,
    .entry_o       (fe_entry),
    .cfg_o         (cfg)
  );

  ytr_queue u_queue (
    .clk_i,
    .rst_ni,
    .wr_i      (take),
    .wr_data_i (fe_entry),
    .full_o    (full),
    .rd_i      (q_pop),
    .valid_o   (q_valid),
    .rd_data_o (q_entry)
  );

  ytr_back u_back (
    .clk_i,
    .rst_ni,
    .cfg_i        (cfg),
    .q_valid_i    (q_valid),
    .q_data_i     (q_entry),
    .q_pop_o      (q_pop),
    .empty,
    .pop,
    .pixel_rgba_o,
    .dest_index_o,
    .frame_last_o
  );

endmodule

[tb/yuv_to_rgba_rotating_writer_test.sv]
// Testbench: random and directed pixels through the YUV to RGBA rotating writer, checked per beat.
module yuv_to_rgba_rotating_writer_test;
  import ytr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_ITEMS  = 2000;
  localparam int LONG_HOLD     = 300;
  localparam int MAX_PRINTS    = 50;
  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [CFG_W-1:0] DIM_CORNERS [7] = '{13'd0, 13'd1, 13'd2, 13'd4095,
                                                   13'd4096, 13'd4097, 13'd8191};
  localparam logic [7:0] SAMPLE_CORNERS [5] = '{8'd0, 8'd16, 8'd128, 8'd235, 8'd255};

  typedef struct packed {
    logic [31:0]      rgba;
    logic [IDX_W-1:0] index;
    logic             last;
  } pixel_result_t;

  typedef enum logic [1:0] {ROW_PIXEL, ROW_CHECKED, ROW_WRITE} row_kind_e;

  typedef struct {
    row_kind_e            kind;
    logic [REG_IDX_W-1:0] reg_idx;
    logic [CFG_W-1:0]     data;
    logic [7:0]           y, u, v;
    pixel_result_t        known;
  } stim_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [REG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0]     cfg_data_i = '0;
  logic                 push = 1'b0;
  logic                 full;
  logic [7:0]           luma_i = '0;
  logic [7:0]           chroma_blue_i = '0;
  logic [7:0]           chroma_red_i = '0;
  logic                 empty;
  logic                 pop = 1'b0;
  logic [31:0]          pixel_rgba_o;
  logic [IDX_W-1:0]     dest_index_o;
  logic                 frame_last_o;

  yuv_to_rgba_rotating_writer dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .push, .full, .luma_i, .chroma_blue_i, .chroma_red_i,
    .empty, .pop, .pixel_rgba_o, .dest_index_o, .frame_last_o
  );

  always #2 clk_i = ~clk_i;

  // Predictor state
  logic [CFG_W-1:0] model_width  = RESET_WIDTH;
  logic [CFG_W-1:0] model_height = RESET_HEIGHT;
  rot_e             model_rot    = ROT_0;
  logic [CNT_W-1:0] model_col    = '0;
  logic [CNT_W-1:0] model_row    = '0;

  pixel_result_t expected_pixels[$];
  int errors = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int take_idle_pct = 0;
  int hold_request = 0;
  int hold_left = 0;

  function automatic int unsigned used_dim(input logic [CFG_W-1:0] d);
    if (d == 0) return 1;
    if (d > MAX_DIM) return MAX_DIM;
    return d;
  endfunction

  function automatic logic [7:0] channel_byte(input int acc);
    if (acc < 0) acc = 0;
    if (acc > 262143) acc = 262143;
    return acc[17:10];
  endfunction

  function automatic logic [31:0] yuv_to_rgba(input logic [7:0] y, u, v);
    int ly, lu, lv;
    ly = int'(y) - 16;
    lu = int'(u) - 128;
    lv = int'(v) - 128;
    if (ly < 0) ly = 0;
    return {8'hff, channel_byte(1192 * ly + 1634 * lv),
            channel_byte(1192 * ly - 833 * lv - 400 * lu),
            channel_byte(1192 * ly + 2066 * lu)};
  endfunction

  function automatic pixel_result_t next_pixel_result(input logic [7:0] y, u, v);
    int unsigned w, h, x, row, idx;
    pixel_result_t r;
    w = used_dim(model_width);
    h = used_dim(model_height);
    x = model_col;
    row = model_row;
    if (x >= w) x = w - 1;
    if (row >= h) row = h - 1;
    case (model_rot)
      ROT_0:   idx = row * w + x;
      ROT_90:  idx = x * h + (h - 1 - row);
      ROT_180: idx = (h - 1 - row) * w + (w - 1 - x);
      default: idx = (w - 1 - x) * h + row;
    endcase
    r.rgba  = yuv_to_rgba(y, u, v);
    r.index = idx[IDX_W-1:0];
    r.last  = (x == w - 1) && (row == h - 1);
    if (x + 1 >= w) begin
      model_col = '0;
      model_row = (row + 1 >= h) ? '0 : CNT_W'(row + 1);
    end else begin
      model_col = CNT_W'(x + 1);
      model_row = CNT_W'(row);
    end
    return r;
  endfunction

  function automatic void apply_register(input logic [REG_IDX_W-1:0] idx,
                                         input logic [CFG_W-1:0] data);
    case (idx)
      REG_WIDTH: begin
        model_width = data;
        model_col = '0;
        model_row = '0;
      end
      REG_HEIGHT: begin
        model_height = data;
        model_col = '0;
        model_row = '0;
      end
      REG_ROTATION: model_rot = rot_e'(data[1:0]);
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (errors < MAX_PRINTS)
      $display("%0t ns: %s mismatch, got %h expected %h", $time, what, got, want);
    errors++;
  endtask

  task automatic write_register(input logic [REG_IDX_W-1:0] idx,
                                input logic [CFG_W-1:0] data);
    push <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    apply_register(idx, data);
  endtask

  task automatic send_pixel(input logic [7:0] y, u, v, input bit typed,
                            input pixel_result_t known);
    pixel_result_t predicted;
    cfg_we_i <= 1'b0;
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push          <= 1'b1;
    luma_i        <= y;
    chroma_blue_i <= u;
    chroma_red_i  <= v;
    do @(posedge clk_i); while (full);
    predicted = next_pixel_result(y, u, v);
    expected_pixels.push_back(typed ? known : predicted);
  endtask

  function automatic stim_row_t pixel_row(input logic [7:0] y, u, v);
    stim_row_t r;
    r.kind = ROW_PIXEL;
    r.y = y;
    r.u = u;
    r.v = v;
    r.known = '0;
    return r;
  endfunction

  function automatic stim_row_t checked_row(input logic [7:0] y, u, v,
                                            input logic [31:0] rgba,
                                            input logic [IDX_W-1:0] index,
                                            input logic last);
    stim_row_t r;
    r = pixel_row(y, u, v);
    r.kind = ROW_CHECKED;
    r.known = '{rgba: rgba, index: index, last: last};
    return r;
  endfunction

  function automatic stim_row_t write_row(input logic [REG_IDX_W-1:0] idx,
                                          input logic [CFG_W-1:0] data);
    stim_row_t r;
    r = pixel_row(8'd0, 8'd0, 8'd0);
    r.kind = ROW_WRITE;
    r.reg_idx = idx;
    r.data = data;
    return r;
  endfunction

  function automatic logic [CFG_W-1:0] pick_dim();
    case ($urandom_range(7))
      0:       return DIM_CORNERS[$urandom_range(6)];
      1:       return CFG_W'($urandom);
      default: return CFG_W'($urandom_range(9, 1));
    endcase
  endfunction

  function automatic logic [7:0] pick_sample();
    if ($urandom_range(9) == 0) return SAMPLE_CORNERS[$urandom_range(4)];
    return 8'($urandom);
  endfunction

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("yuv_to_rgba_rotating_writer_test: FAIL");
      $finish;
    end
  end

  // Receiver side, with an optional long hold-off
  always @(posedge clk_i) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= take_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    pixel_result_t want;
    if (rst_ni && pop && !empty) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch("unexpected beat", pixel_rgba_o, '0);
      end else begin
        want = expected_pixels.pop_front();
        if (pixel_rgba_o !== want.rgba)
          report_mismatch("pixel_rgba", pixel_rgba_o, want.rgba);
        if (dest_index_o !== want.index)
          report_mismatch("dest_index", 32'(dest_index_o), 32'(want.index));
        if (frame_last_o !== want.last)
          report_mismatch("frame_last", 32'(frame_last_o), 32'(want.last));
      end
    end
  end

  initial begin
    stim_row_t plan[$];
    int random_sent;
    int burst;
    bit hold_now;

    plan.push_back(checked_row(8'd0,   8'd0,   8'd0,   32'hff009a00, 24'd0, 1'b0));
    plan.push_back(checked_row(8'd255, 8'd255, 8'd255, 32'hffff7dff, 24'd1, 1'b0));
    plan.push_back(checked_row(8'd16,  8'd128, 8'd128, 32'hff000000, 24'd2, 1'b0));
    plan.push_back(checked_row(8'd235, 8'd128, 8'd128, 32'hfffefefe, 24'd3, 1'b0));
    plan.push_back(pixel_row(8'd81, 8'd90, 8'd240));
    plan.push_back(pixel_row(8'd145, 8'd54, 8'd34));
    plan.push_back(write_row(REG_WIDTH, 13'd0));
    plan.push_back(write_row(REG_HEIGHT, 13'd0));
    plan.push_back(checked_row(8'd16, 8'd128, 8'd128, 32'hff000000, 24'd0, 1'b1));
    plan.push_back(pixel_row(8'd255, 8'd0, 8'd255));
    plan.push_back(write_row(REG_WIDTH, 13'h1fff));
    plan.push_back(write_row(REG_HEIGHT, 13'h1fff));
    plan.push_back(write_row(REG_ROTATION, CFG_W'(ROT_180)));
    plan.push_back(checked_row(8'd16, 8'd128, 8'd128, 32'hff000000, 24'hffffff, 1'b0));
    plan.push_back(checked_row(8'd16, 8'd128, 8'd128, 32'hff000000, 24'hfffffe, 1'b0));
    plan.push_back(write_row(REG_UNUSED, 13'h1fff));
    plan.push_back(pixel_row(8'd0, 8'd255, 8'd0));
    plan.push_back(write_row(REG_ROTATION, CFG_W'(ROT_270)));
    plan.push_back(pixel_row(8'd128, 8'd128, 8'd128));
    plan.push_back(write_row(REG_ROTATION, CFG_W'(ROT_90)));
    plan.push_back(pixel_row(8'd200, 8'd30, 8'd220));
    plan.push_back(write_row(REG_WIDTH, 13'd3));
    plan.push_back(write_row(REG_HEIGHT, 13'd2));
    for (int i = 0; i < 6; i++)
      plan.push_back(pixel_row(8'(40 * i + 10), 8'(255 - 50 * i), 8'(37 * i)));

    send_idle_pct = 27;
    take_idle_pct = 55;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      case (plan[i].kind)
        ROW_WRITE:   write_register(plan[i].reg_idx, plan[i].data);
        ROW_CHECKED: send_pixel(plan[i].y, plan[i].u, plan[i].v, 1'b1, plan[i].known);
        default:     send_pixel(plan[i].y, plan[i].u, plan[i].v, 1'b0, '0);
      endcase
    end

    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      hold_now = 1'b0;
      if (random_sent < 700) begin
        send_idle_pct = 27;
        take_idle_pct = 55;
      end else if (random_sent < 1400) begin
        send_idle_pct = 55;
        take_idle_pct = 27;
      end else begin
        hold_now = (send_idle_pct != 0 || take_idle_pct != 0);
        send_idle_pct = 0;
        take_idle_pct = 0;
      end
      if ($urandom_range(9) < 8) write_register(REG_WIDTH, pick_dim());
      if ($urandom_range(9) < 7) write_register(REG_HEIGHT, pick_dim());
      if ($urandom_range(9) < 6) write_register(REG_ROTATION, CFG_W'($urandom));
      if ($urandom_range(19) == 0) write_register(REG_UNUSED, CFG_W'($urandom));
      // receiver holds off while the burst keeps offering beats
      if (hold_now) hold_request = LONG_HOLD;
      burst = $urandom_range(80, 5);
      repeat (burst) begin
        send_pixel(pick_sample(), pick_sample(), pick_sample(), 1'b0, '0);
        random_sent++;
      end
    end

    push <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("yuv_to_rgba_rotating_writer_test: PASS");
    end else begin
      $display("yuv_to_rgba_rotating_writer_test: FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
design/ytr_pkg.sv
design/ytr_front.sv
design/ytr_queue.sv
design/ytr_back.sv
design/yuv_to_rgba_rotating_writer.sv
tb/yuv_to_rgba_rotating_writer_test.sv
